@@ hw/rtl/mipsdec_pkg.sv @@
// mipsdec_pkg: shared types and codes for the MIPS-I instruction decoder.
// Used by mipsdec_lookup and mips_r3000_instruction_decoder; no dependencies.
`default_nettype none

package mipsdec_pkg;

    // Instruction format codes
    localparam logic [2:0] FMT_UNKNOWN = 3'd0;
    localparam logic [2:0] FMT_R       = 3'd1;
    localparam logic [2:0] FMT_I       = 3'd2;
    localparam logic [2:0] FMT_J       = 3'd3;
    localparam logic [2:0] FMT_COP     = 3'd4;

    localparam int unsigned OPCODE_W = 7;
    localparam int unsigned FORMAT_W = 3;
    localparam int unsigned REG_W    = 5;
    localparam int unsigned IMM_W    = 16;
    localparam int unsigned TARGET_W = 26;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned WORD_W   = 32;

    // Input beat: word in the low half, address in the high half
    localparam int unsigned S_TDATA_W = WORD_W + ADDR_W;
    // Output beat: decoded fields, slot flags, owner address, zero pad to bytes
    localparam int unsigned M_FIELDS_W = OPCODE_W + FORMAT_W + 4 * REG_W + IMM_W
                                       + TARGET_W + 2 + ADDR_W;
    localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Decoded view of one instruction word
    typedef struct packed {
        logic [OPCODE_W-1:0]    opcode_id;
        logic [FORMAT_W-1:0]    format_type;
        logic [REG_W-1:0]       reg_s;
        logic [REG_W-1:0]       reg_t;
        logic [REG_W-1:0]       reg_d;
        logic [REG_W-1:0]       shift_amount;
        logic signed [IMM_W-1:0] immediate_value;
        logic [TARGET_W-1:0]    jump_target;
        logic                   opens_slot;   // branch or jump: next word is a delay slot
    } t_dec;

endpackage

`default_nettype wire

@@ hw/rtl/mipsdec_lookup.sv @@
// mipsdec_lookup: combinational decode of one MIPS-I word into fields and a dense opcode.
// Depends on mipsdec_pkg.
`default_nettype none

module mipsdec_lookup (
    input  wire logic [mipsdec_pkg::WORD_W-1:0] i_word,
    output mipsdec_pkg::t_dec                   o_dec
);
    import mipsdec_pkg::*;

    // Major opcodes
    localparam logic [5:0] MAJ_SPECIAL = 6'h00;
    localparam logic [5:0] MAJ_REGIMM  = 6'h01;
    localparam logic [5:0] MAJ_J       = 6'h02;
    localparam logic [5:0] MAJ_JAL     = 6'h03;
    localparam logic [5:0] MAJ_COP0    = 6'h10;
    localparam logic [5:0] MAJ_COP2    = 6'h12;
    localparam logic [5:0] MAJ_LWC0    = 6'h30;
    localparam logic [5:0] MAJ_LWC2    = 6'h32;
    localparam logic [5:0] MAJ_SWC0    = 6'h38;
    localparam logic [5:0] MAJ_SWC2    = 6'h3A;

    // Dense opcode numbers that matter outside the tables
    localparam logic [6:0] OP_JR     = 7'd25;
    localparam logic [6:0] OP_JALR   = 7'd26;
    localparam logic [6:0] OP_BEQ    = 7'd56;
    localparam logic [6:0] OP_BGTZ   = 7'd59;
    localparam logic [6:0] OP_BLTZ   = 7'd61;
    localparam logic [6:0] OP_BGEZAL = 7'd64;
    localparam logic [6:0] OP_J      = 7'd71;
    localparam logic [6:0] OP_JAL    = 7'd72;
    localparam logic [6:0] OP_BC0F   = 7'd82;
    localparam logic [6:0] OP_BC0T   = 7'd83;
    localparam logic [6:0] OP_LWC2   = 7'd110;
    localparam logic [6:0] OP_LWC0   = 7'd111;
    localparam logic [6:0] OP_SWC2   = 7'd112;
    localparam logic [6:0] OP_SWC0   = 7'd113;
    localparam logic [6:0] OP_NONE   = 7'd0;

    function automatic logic [6:0] f_special(input logic [5:0] funct);
        logic [6:0] id;
        id = OP_NONE;
        case (funct)
            6'h00: id = 7'd11;
            6'h02: id = 7'd12;
            6'h03: id = 7'd13;
            6'h04: id = 7'd14;
            6'h06: id = 7'd15;
            6'h07: id = 7'd16;
            6'h08: id = 7'd25;
            6'h09: id = 7'd26;
            6'h0C: id = 7'd27;
            6'h0D: id = 7'd28;
            6'h0F: id = 7'd29;
            6'h10: id = 7'd21;
            6'h11: id = 7'd22;
            6'h12: id = 7'd23;
            6'h13: id = 7'd24;
            6'h18: id = 7'd17;
            6'h19: id = 7'd18;
            6'h1A: id = 7'd19;
            6'h1B: id = 7'd20;
            6'h20: id = 7'd1;
            6'h21: id = 7'd2;
            6'h22: id = 7'd3;
            6'h23: id = 7'd4;
            6'h24: id = 7'd5;
            6'h25: id = 7'd6;
            6'h26: id = 7'd7;
            6'h27: id = 7'd8;
            6'h2A: id = 7'd9;
            6'h2B: id = 7'd10;
            6'h30: id = 7'd30;
            6'h31: id = 7'd31;
            6'h32: id = 7'd32;
            6'h33: id = 7'd33;
            6'h34: id = 7'd34;
            6'h36: id = 7'd35;
            default: id = OP_NONE;
        endcase
        return id;
    endfunction

    function automatic logic [6:0] f_imm_major(input logic [5:0] major);
        logic [6:0] id;
        id = OP_NONE;
        case (major)
            6'h04: id = 7'd56;
            6'h05: id = 7'd57;
            6'h06: id = 7'd58;
            6'h07: id = 7'd59;
            6'h08: id = 7'd36;
            6'h09: id = 7'd37;
            6'h0A: id = 7'd41;
            6'h0B: id = 7'd42;
            6'h0C: id = 7'd38;
            6'h0D: id = 7'd39;
            6'h0E: id = 7'd40;
            6'h0F: id = 7'd43;
            6'h20: id = 7'd44;
            6'h21: id = 7'd45;
            6'h22: id = 7'd49;
            6'h23: id = 7'd46;
            6'h24: id = 7'd47;
            6'h25: id = 7'd48;
            6'h26: id = 7'd50;
            6'h28: id = 7'd51;
            6'h29: id = 7'd52;
            6'h2A: id = 7'd54;
            6'h2B: id = 7'd53;
            6'h2E: id = 7'd55;
            6'h2F: id = 7'd60;
            default: id = OP_NONE;
        endcase
        return id;
    endfunction

    function automatic logic [6:0] f_regimm(input logic [4:0] rt);
        logic [6:0] id;
        id = OP_NONE;
        case (rt)
            5'h00: id = 7'd61;
            5'h01: id = 7'd62;
            5'h08: id = 7'd65;
            5'h09: id = 7'd66;
            5'h0A: id = 7'd67;
            5'h0B: id = 7'd68;
            5'h0C: id = 7'd69;
            5'h0E: id = 7'd70;
            5'h10: id = 7'd63;
            5'h11: id = 7'd64;
            default: id = OP_NONE;
        endcase
        return id;
    endfunction

    function automatic logic [6:0] f_gte(input logic [5:0] funct);
        logic [6:0] id;
        id = OP_NONE;
        case (funct)
            6'h00: id = 7'd88;
            6'h01: id = 7'd89;
            6'h06: id = 7'd90;
            6'h0C: id = 7'd91;
            6'h10: id = 7'd92;
            6'h11: id = 7'd93;
            6'h12: id = 7'd94;
            6'h13: id = 7'd95;
            6'h14: id = 7'd96;
            6'h16: id = 7'd97;
            6'h1B: id = 7'd98;
            6'h1C: id = 7'd99;
            6'h1E: id = 7'd100;
            6'h20: id = 7'd101;
            6'h28: id = 7'd102;
            6'h29: id = 7'd103;
            6'h2A: id = 7'd104;
            6'h2D: id = 7'd105;
            6'h2E: id = 7'd106;
            6'h3D: id = 7'd107;
            6'h3E: id = 7'd108;
            6'h3F: id = 7'd109;
            default: id = OP_NONE;
        endcase
        return id;
    endfunction

    function automatic logic [6:0] f_cop0(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [5:0] funct);
        logic [6:0] id;
        id = OP_NONE;
        if (rs[4]) begin
            case (funct)
                6'h01: id = 7'd77;
                6'h02: id = 7'd78;
                6'h06: id = 7'd79;
                6'h08: id = 7'd80;
                6'h10: id = 7'd81;
                default: id = OP_NONE;
            endcase
        end else begin
            case (rs)
                5'h00: id = 7'd73;
                5'h04: id = 7'd74;
                5'h02: id = 7'd75;
                5'h06: id = 7'd76;
                5'h08: begin
                    if (rt == 5'd0) begin
                        id = OP_BC0F;
                    end else if (rt == 5'd1) begin
                        id = OP_BC0T;
                    end else begin
                        id = OP_NONE;
                    end
                end
                default: id = OP_NONE;
            endcase
        end
        return id;
    endfunction

    function automatic logic [6:0] f_cop2(input logic [4:0] rs, input logic [5:0] funct);
        logic [6:0] id;
        id = OP_NONE;
        if (rs[4]) begin
            id = f_gte(funct);
        end else begin
            case (rs)
                5'h00: id = 7'd84;
                5'h02: id = 7'd85;
                5'h04: id = 7'd86;
                5'h06: id = 7'd87;
                default: id = OP_NONE;
            endcase
        end
        return id;
    endfunction

    logic [5:0] major;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] rd;
    logic [4:0] sh;
    logic [5:0] funct;
    logic [6:0] id;
    logic [2:0] fmt;

    assign major = i_word[31:26];
    assign rs    = i_word[25:21];
    assign rt    = i_word[20:16];
    assign rd    = i_word[15:11];
    assign sh    = i_word[10:6];
    assign funct = i_word[5:0];

    always_comb begin
        o_dec = '0;
        id    = OP_NONE;
        fmt   = FMT_UNKNOWN;
        case (major)
            MAJ_SPECIAL: begin
                fmt                = FMT_R;
                o_dec.reg_s        = rs;
                o_dec.reg_t        = rt;
                o_dec.reg_d        = rd;
                o_dec.shift_amount = sh;
                id                 = f_special(funct);
            end
            MAJ_J, MAJ_JAL: begin
                fmt               = FMT_J;
                o_dec.jump_target = i_word[25:0];
                id                = (major == MAJ_J) ? OP_J : OP_JAL;
            end
            MAJ_COP0, MAJ_COP2, MAJ_LWC0, MAJ_LWC2, MAJ_SWC0, MAJ_SWC2: begin
                fmt                   = FMT_COP;
                o_dec.reg_s           = rs;
                o_dec.reg_t           = rt;
                o_dec.reg_d           = rd;
                o_dec.immediate_value = i_word[15:0];
                case (major)
                    MAJ_COP0: id = f_cop0(rs, rt, funct);
                    MAJ_COP2: id = f_cop2(rs, funct);
                    MAJ_LWC2: id = OP_LWC2;
                    MAJ_LWC0: id = OP_LWC0;
                    MAJ_SWC2: id = OP_SWC2;
                    default:  id = OP_SWC0;
                endcase
            end
            default: begin
                // everything else, COP1 and COP3 included, takes the immediate form
                fmt                   = FMT_I;
                o_dec.reg_s           = rs;
                o_dec.reg_t           = rt;
                o_dec.immediate_value = i_word[15:0];
                id = (major == MAJ_REGIMM) ? f_regimm(rt) : f_imm_major(major);
            end
        endcase
        o_dec.opcode_id   = id;
        o_dec.format_type = (id == OP_NONE) ? FMT_UNKNOWN : fmt;
        o_dec.opens_slot  = (id == OP_JR) || (id == OP_JALR)
                         || (id >= OP_BEQ && id <= OP_BGTZ)
                         || (id >= OP_BLTZ && id <= OP_BGEZAL)
                         || (id == OP_J) || (id == OP_JAL)
                         || (id == OP_BC0F) || (id == OP_BC0T);
    end

endmodule

`default_nettype wire

@@ hw/rtl/mips_r3000_instruction_decoder.sv @@
// mips_r3000_instruction_decoder: MIPS-I (R3000 + COP0 + GTE) decoder with delay-slot tracking.
// Depends on mipsdec_pkg and mipsdec_lookup.
`default_nettype none

// Channel   Dir  Signals                         Beat contents
// s         in   i_s_tvalid/o_s_tready           tdata: word, address; tlast: block end
// m         out  o_m_tvalid/i_m_tready           tdata: decoded fields, slot info
//
// Each beat passes through an input register, then decodes into the output
// register. One word per cycle sustained while m accepts; the decode tables
// and the slot state (flag, owner address) are all between the two registers.
// Reset (i_rst_n low, synchronous) empties both stages and clears the slot state.
// A stall on m holds the output register; s keeps accepting until the input
// register is also full, then o_s_tready drops until m drains.

module mips_r3000_instruction_decoder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // s: [31:0] instruction_word, [63:32] word_address
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [mipsdec_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  wire logic                                i_s_tlast,     // block_end
    // m: [6:0] opcode_id, [9:7] format_type, [14:10] reg_s, [19:15] reg_t,
    //    [24:20] reg_d, [29:25] shift_amount, [45:30] immediate_value,
    //    [71:46] jump_target, [72] in_delay_slot, [73] owner_valid,
    //    [105:74] owner_address, [111:106] zero
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [mipsdec_pkg::M_TDATA_W-1:0]        o_m_tdata
);
    import mipsdec_pkg::*;

    // input stage
    logic                r_s1_valid;
    logic [WORD_W-1:0]   r_s1_word;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic                r_s1_last;

    // output stage
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data;
    logic [M_TDATA_W-1:0]  n_out_data;

    // delay-slot tracking, advanced as each word moves into the output stage
    logic                r_pend_slot;
    logic [ADDR_W-1:0]   r_pend_owner;
    logic                n_pend_slot;
    logic [ADDR_W-1:0]   n_pend_owner;

    t_dec                dec;
    logic                out_free;
    logic                advance;

    mipsdec_lookup u_lookup (
        .i_word (r_s1_word),
        .o_dec  (dec)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || out_free;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_out_data = {(M_TDATA_W - M_FIELDS_W)'(0),
                      (r_pend_slot ? r_pend_owner : ADDR_W'(0)),
                      r_pend_slot,
                      r_pend_slot,
                      dec.jump_target,
                      dec.immediate_value,
                      dec.shift_amount,
                      dec.reg_d,
                      dec.reg_t,
                      dec.reg_s,
                      dec.format_type,
                      dec.opcode_id};

        // block end clears tracking; otherwise a branch or jump opens a slot
        if (r_s1_last || !dec.opens_slot) begin
            n_pend_slot  = 1'b0;
            n_pend_owner = '0;
        end else begin
            n_pend_slot  = 1'b1;
            n_pend_owner = r_s1_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pend_slot  <= 1'b0;
            r_pend_owner <= '0;
        end else begin
            if (o_s_tready) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (advance) begin
                r_pend_slot  <= n_pend_slot;
                r_pend_owner <= n_pend_owner;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_word <= i_s_tdata[WORD_W-1:0];
            r_s1_addr <= i_s_tdata[WORD_W +: ADDR_W];
            r_s1_last <= i_s_tlast;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire
